// File: rtl/tsat_pkg.sv
// ----------------------------------------------------------------------------
// TLB shootdown tracker package
// Shared types and codes for the shootdown acknowledgement tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsat_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned CORE_W = 6;
  localparam int unsigned MASK_W = 64;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned CFGI_W = 3;

  // Stream widths: request is 72 bits, result 260 bits padded to 264
  localparam int unsigned IN_W     = 72;
  localparam int unsigned OUT_W    = 260;
  localparam int unsigned OUT_PADW = 264;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_SERVICE = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    STS_NONE          = 3'd0,
    STS_STARTED       = 3'd1,
    STS_COMPLETE      = 3'd2,
    STS_BUSY          = 3'd3,
    STS_NO_TARGETS    = 3'd4,
    STS_TIMEOUT       = 3'd5,
    STS_SEQ_EXHAUSTED = 3'd6
  } status_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CORE_ENABLE = 3'd0,
    CFG_SELF_CORE   = 3'd1,
    CFG_SD_ENABLE   = 3'd2,
    CFG_RETRY       = 3'd3,
    CFG_TIMEOUT     = 3'd4
  } cfg_idx_e;

  // Request item, last field in the lowest bits
  typedef struct packed {
    logic [CORE_W-1:0] core_index;
    logic [ADDR_W-1:0] flush_address;
    req_e              req_type;
  } item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [SEQ_W-1:0]  sequence_now;
    logic [MASK_W-1:0] pending_mask;
    logic [ADDR_W-1:0] flush_target;
    logic              flush_valid;
    logic [MASK_W-1:0] ipi_mask;
    status_e           status;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/tsat_ctrl.sv
// ----------------------------------------------------------------------------
// TLB shootdown tracker controller
// Sequences capture and execution of one request and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tsat_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tsat_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec_go;

  // Execute only when the result register is free or being drained
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    exec_go       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.exec    = exec_go;
    out_valid_o   = out_valid_q;
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A captured request always moves to the execution state next
  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC))
    else $error("captured request did not move to execution");

  // Execution always presents a result
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("execution did not present a result");

  // A pending undrained result blocks execution
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.exec)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// File: rtl/tsat_datapath.sv
// ----------------------------------------------------------------------------
// TLB shootdown tracker datapath
// Configuration registers, shootdown state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsat_datapath #(
  parameter int unsigned MAX_TARGETS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tsat_pkg::CFGI_W-1:0]  cfg_index_i,
  input  wire logic [tsat_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire tsat_pkg::item_t              item_i,
  input  wire tsat_pkg::cmd_t               cmd_i,
  output tsat_pkg::result_t                 result_o
);

  localparam int unsigned MW = tsat_pkg::MASK_W;
  localparam int unsigned TW = tsat_pkg::TICK_W;
  localparam int unsigned CW = tsat_pkg::CORE_W;

  // Cores that exist for this build
  localparam logic [MW-1:0] RANGE_MASK = (MAX_TARGETS >= MW) ? {MW{1'b1}} :
                                         ((MW'(1) << MAX_TARGETS) - MW'(1));
  localparam logic [CW:0]   CORE_LIMIT = (CW+1)'(MAX_TARGETS);

  // Configuration registers
  logic [MW-1:0]            enable_q;
  logic [CW-1:0]            self_q;
  logic                     sd_en_q;
  logic [TW-1:0]            retry_lim_q;
  logic [TW-1:0]            timeout_lim_q;

  // Shootdown state
  tsat_pkg::item_t          item_q;
  logic [tsat_pkg::SEQ_W-1:0]  seq_q, seq_d;
  logic [MW-1:0]            target_q, target_d;
  logic [MW-1:0]            acked_q, acked_d;
  logic [tsat_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic                     busy_q, busy_d;
  logic [TW-1:0]            retry_q, retry_d;
  logic [TW-1:0]            timeout_q, timeout_d;
  tsat_pkg::result_t        result_q, result_d;

  // Working values
  logic [MW-1:0]            targets;
  logic [MW-1:0]            core_bit;
  logic [MW-1:0]            acked_new;
  logic [TW-1:0]            retry_inc;
  logic [TW-1:0]            timeout_inc;
  logic [TW-1:0]            retry_lim;
  logic [TW-1:0]            timeout_lim;
  logic                     use_report;
  logic [MW-1:0]            report;

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= '0;
      self_q        <= '0;
      sd_en_q       <= 1'b0;
      retry_lim_q   <= TW'(10);
      timeout_lim_q <= TW'(5000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsat_pkg::CFG_CORE_ENABLE: enable_q      <= cfg_wdata_i;
        tsat_pkg::CFG_SELF_CORE:   self_q        <= cfg_wdata_i[CW-1:0];
        tsat_pkg::CFG_SD_ENABLE:   sd_en_q       <= cfg_wdata_i[0];
        tsat_pkg::CFG_RETRY:       retry_lim_q   <= cfg_wdata_i[TW-1:0];
        tsat_pkg::CFG_TIMEOUT:     timeout_lim_q <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // Request execution. A core's last-seen sequence lags the current one
  // exactly when it is targeted and has not yet acknowledged, so the acked
  // mask stands in for the per-core last-seen store.
  always_comb begin
    seq_d      = seq_q;
    target_d   = target_q;
    acked_d    = acked_q;
    addr_d     = addr_q;
    busy_d     = busy_q;
    retry_d    = retry_q;
    timeout_d  = timeout_q;
    use_report = 1'b0;
    report     = target_q & ~acked_q;

    result_d              = '0;
    result_d.status       = tsat_pkg::STS_NONE;

    targets = '0;
    if (sd_en_q && ({1'b0, self_q} < CORE_LIMIT)) begin
      targets = enable_q & RANGE_MASK & ~(MW'(1) << self_q);
    end
    core_bit    = MW'(1) << item_q.core_index;
    acked_new   = acked_q | core_bit;
    retry_inc   = retry_q + TW'(1);
    timeout_inc = timeout_q + TW'(1);
    retry_lim   = (retry_lim_q == '0) ? TW'(1) : retry_lim_q;
    timeout_lim = (timeout_lim_q == '0) ? TW'(1) : timeout_lim_q;

    case (item_q.req_type)
      tsat_pkg::REQ_START: begin
        if (busy_q) begin
          result_d.status = tsat_pkg::STS_BUSY;
        end else if (targets == '0) begin
          result_d.status = tsat_pkg::STS_NO_TARGETS;
        end else if (seq_q == {tsat_pkg::SEQ_W{1'b1}}) begin
          result_d.status = tsat_pkg::STS_SEQ_EXHAUSTED;
        end else begin
          seq_d             = seq_q + tsat_pkg::SEQ_W'(1);
          addr_d            = item_q.flush_address;
          target_d          = targets;
          acked_d           = '0;
          busy_d            = 1'b1;
          retry_d           = '0;
          timeout_d         = '0;
          result_d.status   = tsat_pkg::STS_STARTED;
          result_d.ipi_mask = targets;
        end
      end
      tsat_pkg::REQ_SERVICE: begin
        if (target_q[item_q.core_index] && !acked_q[item_q.core_index]) begin
          result_d.flush_valid  = 1'b1;
          result_d.flush_target = addr_q;
          acked_d               = acked_new;
          if ((acked_new & target_q) == target_q) begin
            result_d.status = tsat_pkg::STS_COMPLETE;
            busy_d          = 1'b0;
            target_d        = '0;
            acked_d         = '0;
            retry_d         = '0;
            timeout_d       = '0;
          end
        end
      end
      tsat_pkg::REQ_TICK: begin
        if (busy_q) begin
          if (timeout_inc >= timeout_lim) begin
            result_d.status = tsat_pkg::STS_TIMEOUT;
            use_report      = 1'b1;
            busy_d          = 1'b0;
            target_d        = '0;
            acked_d         = '0;
            retry_d         = '0;
            timeout_d       = '0;
          end else if (retry_inc >= retry_lim) begin
            result_d.ipi_mask = target_q & ~acked_q;
            retry_d           = '0;
            timeout_d         = timeout_inc;
          end else begin
            retry_d   = retry_inc;
            timeout_d = timeout_inc;
          end
        end
      end
      default: ;
    endcase

    result_d.pending_mask = use_report ? report : (target_d & ~acked_d);
    result_d.sequence_now = seq_d;
  end

  // Request capture and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      result_q <= result_d;
      addr_q   <= addr_d;
    end
  end

  // Tracker control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= '0;
      target_q  <= '0;
      acked_q   <= '0;
      busy_q    <= 1'b0;
      retry_q   <= '0;
      timeout_q <= '0;
    end else if (cmd_i.exec) begin
      seq_q     <= seq_d;
      target_q  <= target_d;
      acked_q   <= acked_d;
      busy_q    <= busy_d;
      retry_q   <= retry_d;
      timeout_q <= timeout_d;
    end
  end

  assign result_o = result_q;

  // Acknowledgements only ever come from targeted cores
  a_acked_in_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acked_q & ~target_q) == '0)
    else $error("acknowledgement from a core that was not targeted");

  // An idle tracker holds no targets
  a_idle_no_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (target_q == '0))
    else $error("targets held while no shootdown is active");

  // An active shootdown always carries a non-zero sequence number
  a_busy_has_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (seq_q != '0))
    else $error("shootdown active with sequence zero");

endmodule

`default_nettype wire

// File: rtl/tlb_shootdown_ack_tracker_unit.sv
// Operation: a request is captured into the item register and then executed,
// which registers its result; no new request is accepted until the captured
// one has executed, and a result waiting downstream holds execution of the
// next captured request.
// Reset: configuration returns to its defaults, the tracker is idle with
// sequence zero and no targets; the block accepts requests right after reset.
// ----------------------------------------------------------------------------
// TLB shootdown acknowledgement tracker
// Runs one shootdown at a time, tracks acknowledgements, retries and timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_shootdown_ack_tracker_unit #(
  parameter int unsigned MAX_TARGETS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [tsat_pkg::CFGI_W-1:0]   cfg_index_i,
  input  wire logic [tsat_pkg::CFG_W-1:0]    cfg_wdata_i,
  // Request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: req_type[1:0], flush_address[65:2], core_index[71:66]
  input  wire logic [tsat_pkg::IN_W-1:0]     s_axis_tdata,
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: status[2:0], ipi_mask[66:3], flush_valid[67], flush_target[131:68],
  // pending_mask[195:132], sequence_now[259:196], zero[263:260]
  output logic [tsat_pkg::OUT_PADW-1:0]      m_axis_tdata
);

  tsat_pkg::cmd_t    cmd;
  tsat_pkg::item_t   item;
  tsat_pkg::result_t result;

  assign item = tsat_pkg::item_t'(s_axis_tdata);

  // Controller
  tsat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Datapath
  tsat_datapath #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .result_o    (result)
  );

  assign m_axis_tdata = {{(tsat_pkg::OUT_PADW - tsat_pkg::OUT_W){1'b0}}, result};

endmodule

`default_nettype wire

// File: tb/sv/tlb_shootdown_ack_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// TLB shootdown tracker testbench
// Drives start, service, tick and no-op requests into the tracker and checks
// every result against a cycle-free model of the tracker kept in the bench.
// A short directed sequence covers the corner cases. Randomised shootdown
// episodes then run under several configurations and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_shootdown_ack_tracker_unit_test;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [tsat_pkg::CFGI_W-1:0]   cfg_index_i   = '0;
  logic [tsat_pkg::CFG_W-1:0]    cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // tdata: req_type, flush_address, core_index
  logic [tsat_pkg::IN_W-1:0]     s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // tdata: status, ipi_mask, flush_valid, flush_target, pending_mask,
  // sequence_now, zero padding
  logic [tsat_pkg::OUT_PADW-1:0] m_axis_tdata;

  tlb_shootdown_ack_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [63:0] cfg_en_mask = '0;
  logic [5:0]  cfg_self    = '0;
  logic        cfg_sd_en   = 1'b0;
  logic [31:0] cfg_retry   = 32'd10;
  logic [31:0] cfg_tmo     = 32'd5000;

  // Shadow copy of the tracker state.
  logic [63:0] seq_num   = '0;
  logic [63:0] last_seen [64];
  logic [63:0] tgt_mask  = '0;
  logic [63:0] ack_mask  = '0;
  logic [63:0] pend_addr = '0;
  logic        busy      = 1'b0;
  logic [31:0] retry_cnt = '0;
  logic [31:0] tmo_cnt   = '0;

  tsat_pkg::item_t   request_q [$];
  tsat_pkg::result_t expected_results [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned queued_count    = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  logic        req_taken       = 1'b0;

  initial begin
    foreach (last_seen[i]) last_seen[i] = '0;
  end

  // Drop the current shootdown and return to idle.
  function automatic void clear_request();
    busy      = 1'b0;
    tgt_mask  = '0;
    ack_mask  = '0;
    pend_addr = '0;
    retry_cnt = '0;
    tmo_cnt   = '0;
  endfunction

  // Works out the result of one request and advances the shadow state.
  function automatic tsat_pkg::result_t shootdown_outcome(tsat_pkg::item_t it);
    tsat_pkg::result_t r;
    logic [63:0] tgts;
    logic [63:0] bit_m;
    logic [63:0] report;
    logic        use_report;
    logic [31:0] rlim;
    logic [31:0] tlim;
    r          = '0;
    r.status   = tsat_pkg::STS_NONE;
    report     = '0;
    use_report = 1'b0;
    case (it.req_type)
      tsat_pkg::REQ_START: begin
        if (busy) begin
          r.status = tsat_pkg::STS_BUSY;
        end else begin
          tgts = cfg_sd_en ? (cfg_en_mask & ~(64'd1 << cfg_self)) : 64'd0;
          if (tgts == '0) begin
            r.status = tsat_pkg::STS_NO_TARGETS;
          end else if (seq_num == '1) begin
            r.status = tsat_pkg::STS_SEQ_EXHAUSTED;
          end else begin
            seq_num    = seq_num + 64'd1;
            pend_addr  = it.flush_address;
            tgt_mask   = tgts;
            ack_mask   = '0;
            busy       = 1'b1;
            retry_cnt  = '0;
            tmo_cnt    = '0;
            r.status   = tsat_pkg::STS_STARTED;
            r.ipi_mask = tgts;
          end
        end
      end
      tsat_pkg::REQ_SERVICE: begin
        bit_m = 64'd1 << it.core_index;
        if (seq_num != '0 && last_seen[it.core_index] < seq_num &&
            (tgt_mask & bit_m) != '0) begin
          r.flush_valid            = 1'b1;
          r.flush_target           = pend_addr;
          last_seen[it.core_index] = seq_num;
          ack_mask                 = ack_mask | bit_m;
          if (busy && (ack_mask & tgt_mask) == tgt_mask) begin
            r.status = tsat_pkg::STS_COMPLETE;
            clear_request();
          end
        end
      end
      tsat_pkg::REQ_TICK: begin
        if (busy) begin
          rlim      = (cfg_retry == '0) ? 32'd1 : cfg_retry;
          tlim      = (cfg_tmo == '0) ? 32'd1 : cfg_tmo;
          retry_cnt = retry_cnt + 32'd1;
          tmo_cnt   = tmo_cnt + 32'd1;
          if (tmo_cnt >= tlim) begin
            // The timeout takes priority over a retry due on the same tick.
            r.status   = tsat_pkg::STS_TIMEOUT;
            report     = tgt_mask & ~ack_mask;
            use_report = 1'b1;
            clear_request();
          end else if (retry_cnt >= rlim) begin
            r.ipi_mask = tgt_mask & ~ack_mask;
            retry_cnt  = '0;
          end
        end
      end
      default: begin
      end
    endcase
    r.pending_mask = use_report ? report : (tgt_mask & ~ack_mask);
    r.sequence_now = seq_num;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Request driver: presents the next queued request at the falling edge.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || req_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_axis_tdata  <= request_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: checks each result and records the outcome of each request.
  always @(posedge clk_i) begin
    tsat_pkg::result_t got;
    tsat_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = tsat_pkg::result_t'(m_axis_tdata[tsat_pkg::OUT_W-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("ipi_mask", want.ipi_mask, got.ipi_mask);
          check_field("flush_valid", 64'(want.flush_valid), 64'(got.flush_valid));
          check_field("flush_target", want.flush_target, got.flush_target);
          check_field("pending_mask", want.pending_mask, got.pending_mask);
          check_field("sequence_now", want.sequence_now, got.sequence_now);
          check_field("padding", 64'd0,
                      64'(m_axis_tdata[tsat_pkg::OUT_PADW-1:tsat_pkg::OUT_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(shootdown_outcome(tsat_pkg::item_t'(s_axis_tdata)));
      end
    end
    req_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tlb_shootdown_ack_tracker_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(tsat_pkg::cfg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      tsat_pkg::CFG_CORE_ENABLE: cfg_en_mask = value;
      tsat_pkg::CFG_SELF_CORE:   cfg_self    = value[5:0];
      tsat_pkg::CFG_SD_ENABLE:   cfg_sd_en   = value[0];
      tsat_pkg::CFG_RETRY:       cfg_retry   = value[31:0];
      tsat_pkg::CFG_TIMEOUT:     cfg_tmo     = value[31:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued request has been answered and the block is quiet.
  task automatic settle();
    while (request_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] sparse_mask();
    logic [63:0] m;
    m = '0;
    repeat ($urandom_range(2, 6)) m[$urandom_range(63)] = 1'b1;
    return m;
  endfunction

  task automatic queue_request(tsat_pkg::req_e kind, logic [63:0] addr, logic [5:0] core);
    tsat_pkg::item_t it;
    it.req_type      = kind;
    it.flush_address = addr;
    it.core_index    = core;
    request_q.push_back(it);
    if (kind != tsat_pkg::REQ_NOP) queued_count++;
  endtask

  task automatic queue_noise();
    queue_request(tsat_pkg::req_e'($urandom_range(3)), rand_addr(),
                  6'($urandom_range(63)));
  endtask

  task automatic queue_tick();
    queue_request(tsat_pkg::REQ_TICK, rand_addr(), 6'($urandom_range(63)));
  endtask

  // One shootdown: a start, then the targets answering in random order with
  // ticks and stray requests mixed in. Sometimes a target stays silent and
  // the episode is run out to its timeout.
  task automatic queue_episode();
    logic [63:0] tgts;
    int          order [$];
    int          j;
    int          tmp;
    bit          silent;
    tgts   = cfg_sd_en ? (cfg_en_mask & ~(64'd1 << cfg_self)) : 64'd0;
    silent = 1'b0;
    queue_request(tsat_pkg::REQ_START, rand_addr(), 6'($urandom_range(63)));
    for (int c = 0; c < 64; c++) if (tgts[c]) order.push_back(c);
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 2)) queue_tick();
      if ($urandom_range(99) < 6) queue_noise();
      if (cfg_tmo <= 64 && $urandom_range(99) < 8) begin
        silent = 1'b1;
      end else begin
        queue_request(tsat_pkg::REQ_SERVICE, rand_addr(), 6'(order[k]));
        if ($urandom_range(99) < 5) begin
          queue_request(tsat_pkg::REQ_SERVICE, rand_addr(), 6'(order[k]));
        end
      end
    end
    if (silent) repeat ((cfg_tmo == '0) ? 1 : cfg_tmo) queue_tick();
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned stall_pct,
                           int unsigned n_items, bit hold_midway);
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
    queued_count    = 0;
    while (queued_count < n_items / 2) queue_episode();
    // Let the block drain completely before carrying on.
    if (hold_midway) settle();
    while (queued_count < n_items) queue_episode();
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: shootdowns disabled, no cores enabled.
    queue_tick();
    queue_request(tsat_pkg::REQ_NOP, '1, '1);
    queue_request(tsat_pkg::REQ_START, '1, 6'd0);
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd63);
    settle();
    write_reg(tsat_pkg::CFG_SD_ENABLE, 64'd1);
    queue_request(tsat_pkg::REQ_START, '1, 6'd0);
    settle();

    // Targets are cores five and sixty-three; retry every two ticks.
    write_reg(tsat_pkg::CFG_CORE_ENABLE, (64'd1 << 63) | (64'd1 << 5) | 64'd1);
    write_reg(tsat_pkg::CFG_SELF_CORE, 64'd0);
    write_reg(tsat_pkg::CFG_RETRY, 64'd2);
    write_reg(tsat_pkg::CFG_TIMEOUT, 64'd6);
    queue_request(tsat_pkg::REQ_START, '1, 6'd0);
    queue_request(tsat_pkg::REQ_START, '0, 6'd0);
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd0);
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd17);
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd5);
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd5);
    queue_tick();
    queue_tick();
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd63);
    // Nobody answers: retries, then a timeout on a tick where a retry is due.
    queue_request(tsat_pkg::REQ_START, '0, 6'd0);
    repeat (6) queue_tick();
    queue_request(tsat_pkg::REQ_SERVICE, '0, 6'd5);
    settle();

    // The only enabled core is the initiator itself.
    write_reg(tsat_pkg::CFG_SELF_CORE, 64'd5);
    write_reg(tsat_pkg::CFG_CORE_ENABLE, 64'd1 << 5);
    queue_request(tsat_pkg::REQ_START, rand_addr(), 6'd0);
    settle();

    write_reg(tsat_pkg::CFG_CORE_ENABLE, sparse_mask() | (64'd1 << 63) | 64'd1);
    write_reg(tsat_pkg::CFG_SELF_CORE, 64'($urandom_range(63)));
    write_reg(tsat_pkg::CFG_RETRY, 64'd0);
    write_reg(tsat_pkg::CFG_TIMEOUT, 64'hFFFF_FFFF);
    run_phase(0, 0, 110, 1'b0);

    write_reg(tsat_pkg::CFG_CORE_ENABLE, '1);
    write_reg(tsat_pkg::CFG_SELF_CORE, 64'd63);
    write_reg(tsat_pkg::CFG_RETRY, 64'd1);
    write_reg(tsat_pkg::CFG_TIMEOUT, 64'd40);
    run_phase(85, 0, 120, 1'b1);

    write_reg(tsat_pkg::CFG_CORE_ENABLE, sparse_mask());
    write_reg(tsat_pkg::CFG_SELF_CORE, 64'd0);
    write_reg(tsat_pkg::CFG_RETRY, 64'hFFFF_FFFF);
    write_reg(tsat_pkg::CFG_TIMEOUT, 64'd30);
    run_phase(0, 85, 110, 1'b0);

    write_reg(tsat_pkg::CFG_CORE_ENABLE, sparse_mask() | sparse_mask());
    write_reg(tsat_pkg::CFG_SELF_CORE, 64'($urandom_range(63)));
    write_reg(tsat_pkg::CFG_RETRY, 64'd3);
    write_reg(tsat_pkg::CFG_TIMEOUT, 64'd25);
    run_phase(15, 15, 110, 1'b0);

    // A zero timeout abandons a shootdown on its first tick.
    write_reg(tsat_pkg::CFG_RETRY, 64'd1);
    write_reg(tsat_pkg::CFG_TIMEOUT, 64'd0);
    run_phase(0, 0, 20, 1'b0);

    if (error_count == 0) begin
      $display("tlb_shootdown_ack_tracker_unit test passed");
    end else begin
      $display("tlb_shootdown_ack_tracker_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/tsat_pkg.sv
rtl/tsat_ctrl.sv
rtl/tsat_datapath.sv
rtl/tlb_shootdown_ack_tracker_unit.sv
tb/sv/tlb_shootdown_ack_tracker_unit_test.sv
